// ===== src/ddm_pkg.sv =====
// ----------------------------------------------------------------------------
// ddm_pkg
// Shared types, constants and a digit helper for the decimal digit masker.
// ----------------------------------------------------------------------------
package ddm_pkg;

  localparam int DATA_W      = 64;
  localparam int BCD_DIGITS  = 19;
  localparam int DIGIT_W     = 4;
  localparam int COUNT_W     = 5;
  localparam int DABBLE_BITS = 4;
  localparam int DABBLE_STEPS = DATA_W / DABBLE_BITS;
  localparam int DABBLE_CNT_W = $clog2(DABBLE_STEPS);

  typedef logic [DIGIT_W-1:0]            digit_t;
  typedef digit_t [BCD_DIGITS-1:0]       bcd_t;
  typedef logic [DATA_W-1:0]             word_t;
  typedef logic [COUNT_W-1:0]            count_t;

  typedef enum logic [1:0] {
    CFG_KEEP_MODE  = 2'd0,
    CFG_KEEP_COUNT = 2'd1,
    CFG_MASK_DIGIT = 2'd2
  } cfg_index_t;

  localparam logic   KEEP_MODE_RESET  = 1'b0;
  localparam count_t KEEP_COUNT_RESET = count_t'(4);
  localparam digit_t MASK_DIGIT_RESET = digit_t'(1);
  localparam digit_t DIGIT_MAX        = digit_t'(9);
  localparam digit_t DIGIT_ADJ_MIN    = digit_t'(5);
  localparam digit_t DIGIT_ADJ        = digit_t'(3);

  localparam word_t POS_LIMIT = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t NEG_LIMIT = {1'b1, {(DATA_W-1){1'b0}}};

  // add-3 correction on every digit ahead of a shift
  function automatic bcd_t dabble_adjust(input bcd_t b);
    bcd_t r;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      r[i] = (b[i] >= DIGIT_ADJ_MIN) ? digit_t'(b[i] + DIGIT_ADJ) : b[i];
    end
    return r;
  endfunction

endpackage

// ===== src/ddm_dabble.sv =====
// ----------------------------------------------------------------------------
// ddm_dabble
// Iterative binary to BCD converter, four shift-and-adjust steps per cycle.
// ----------------------------------------------------------------------------
module ddm_dabble import ddm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t mag,
  output logic  done,
  output bcd_t  bcd
);

  logic                    busy;
  logic [DABBLE_CNT_W-1:0] cnt;
  word_t                   sh;
  bcd_t                    bcd_next;
  word_t                   sh_next;

  always_comb begin
    bcd_next = bcd;
    sh_next  = sh;
    for (int k = 0; k < DABBLE_BITS; k++) begin
      bcd_next = dabble_adjust(bcd_next);
      bcd_next = bcd_t'({bcd_next, sh_next[DATA_W-1]});
      sh_next  = {sh_next[DATA_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DABBLE_CNT_W'(1);
        if (cnt == DABBLE_CNT_W'(DABBLE_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= mag;
      bcd <= '0;
    end else if (busy) begin
      sh  <= sh_next;
      bcd <= bcd_next;
    end
  end

endmodule

// ===== src/ddm_rebuild.sv =====
// ----------------------------------------------------------------------------
// ddm_rebuild
// Iterative BCD to binary converter, one digit per cycle, top digit first.
// ----------------------------------------------------------------------------
module ddm_rebuild import ddm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  bcd_t  bcd,
  output logic  done,
  output word_t acc
);

  logic   busy;
  count_t cnt;
  bcd_t   sh;
  word_t  acc_next;

  // acc * 10 + digit; the full result stays below 10^19, so no bits are lost
  assign acc_next = {acc[DATA_W-4:0], 3'b000} + {acc[DATA_W-2:0], 1'b0}
                  + word_t'(sh[BCD_DIGITS-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + count_t'(1);
        if (cnt == count_t'(BCD_DIGITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= bcd;
      acc <= '0;
    end else if (busy) begin
      sh  <= bcd_t'({sh[BCD_DIGITS-2:0], digit_t'(0)});
      acc <= acc_next;
    end
  end

endmodule

// ===== src/decimal_digit_masker_unit.sv =====
// ----------------------------------------------------------------------------
// decimal_digit_masker_unit
// Replaces leading or trailing decimal digits of a signed 64-bit item.
// ----------------------------------------------------------------------------
// Flow: the magnitude is converted to BCD, 4 bits a cycle; if no digit is masked,
// the input item leaves unchanged, otherwise the masked digits are rebuilt to binary,
// one digit a cycle, and the sign is restored with saturation.
// Throughput: one item at a time; the next item is taken once the result leaves.
// Reset: synchronous; keep_mode 0, keep_count 4, mask_digit 1, unit idle.
module decimal_digit_masker_unit import ddm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [DATA_W-1:0]  s_axis_tdata,   // [63:0] value
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [DATA_W-1:0]  m_axis_tdata,   // [63:0] masked_value
  output logic               m_axis_tuser,   // [0] overflow
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [COUNT_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_MASK,
    S_BUILD,
    S_OUT
  } state_t;

  state_t state;
  logic   keep_mode;
  count_t keep_count;
  digit_t mask_digit;
  word_t  raw;
  logic   neg;

  logic   in_acc;
  word_t  in_mag;
  logic   conv_done;
  bcd_t   conv_bcd;
  logic   build_start;
  logic   build_done;
  word_t  build_acc;

  count_t n_digits;
  count_t m_low;
  digit_t fill;
  bcd_t   masked;
  logic   pass;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_mag        = s_axis_tdata[DATA_W-1] ? (~s_axis_tdata + word_t'(1)) : s_axis_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_mode  <= KEEP_MODE_RESET;
      keep_count <= KEEP_COUNT_RESET;
      mask_digit <= MASK_DIGIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEEP_MODE:  keep_mode  <= cfg_data[0];
        CFG_KEEP_COUNT: keep_count <= cfg_data;
        CFG_MASK_DIGIT: mask_digit <= cfg_data[DIGIT_W-1:0];
        default: ;
      endcase
    end
  end

  ddm_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (in_acc),
    .mag   (in_mag),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  // digit count and per-digit replacement
  always_comb begin
    n_digits = '0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (conv_bcd[i] != '0) n_digits = count_t'(i + 1);
    end
    pass  = (keep_count >= n_digits);
    m_low = n_digits - keep_count;
    fill  = (mask_digit > DIGIT_MAX) ? DIGIT_MAX : mask_digit;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (keep_mode) begin
        masked[i] = (count_t'(i) >= keep_count && count_t'(i) < n_digits) ? fill
                                                                          : conv_bcd[i];
      end else begin
        masked[i] = (count_t'(i) < m_low) ? fill : conv_bcd[i];
      end
    end
  end

  assign build_start = (state == S_MASK) && !pass;

  ddm_rebuild u_rebuild (
    .clk   (clk),
    .rst   (rst),
    .start (build_start),
    .bcd   (masked),
    .done  (build_done),
    .acc   (build_acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      m_axis_tdata <= '0;
      m_axis_tuser <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) state <= S_CONV;
        end
        S_CONV: begin
          if (conv_done) state <= S_MASK;
        end
        S_MASK: begin
          if (pass) begin
            m_axis_tdata <= raw;
            m_axis_tuser <= 1'b0;
            state        <= S_OUT;
          end else begin
            state <= S_BUILD;
          end
        end
        S_BUILD: begin
          if (build_done) begin
            if (!neg) begin
              m_axis_tdata <= (build_acc > POS_LIMIT) ? POS_LIMIT : build_acc;
              m_axis_tuser <= (build_acc > POS_LIMIT);
            end else begin
              m_axis_tdata <= (build_acc > NEG_LIMIT) ? NEG_LIMIT
                                                      : (~build_acc + word_t'(1));
              m_axis_tuser <= (build_acc > NEG_LIMIT);
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_axis_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      raw <= s_axis_tdata;
      neg <= s_axis_tdata[DATA_W-1];
    end
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input and output sides open together");

  a_conv_state: assert property (@(posedge clk) disable iff (rst)
    conv_done |-> (state == S_CONV))
    else $error("conversion finished outside its state");

  a_build_state: assert property (@(posedge clk) disable iff (rst)
    build_done |-> (state == S_BUILD))
    else $error("rebuild finished outside its state");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == POS_LIMIT || m_axis_tdata == NEG_LIMIT))
    else $error("overflow flagged on an unsaturated item");

endmodule

// ===== tb/tb_decimal_digit_masker_unit.sv =====
// ----------------------------------------------------------------------------
// tb_decimal_digit_masker_unit
// Self-checking bench for the decimal digit masker. A short table of directed
// items covers reset settings, both keep modes, count and digit extremes and
// saturation. Random values over several register settings follow. Each
// result is compared with its table entry or with an in-bench model of the
// digit masking, with random idling on either stream in most phases.
// ----------------------------------------------------------------------------
module tb_decimal_digit_masker_unit;
  import ddm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 60;
  localparam int NUM_PHASES     = 12;
  localparam int PHASE_ITEMS    = 100;
  localparam int NUM_ROWS       = 25;

  typedef struct packed {
    word_t value;
    logic  ovf;
  } masked_t;

  typedef struct packed {
    logic   mode;
    count_t keep;
    digit_t dig;
    word_t  value;
    logic   typed;
    word_t  want;
    logic   want_ovf;
  } row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [DATA_W-1:0]  s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [DATA_W-1:0]  m_axis_tdata;
  logic               m_axis_tuser;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = CFG_KEEP_MODE;
  logic [COUNT_W-1:0] cfg_data = '0;

  masked_t awaited_masks[$];
  int      errors = 0;
  int      hold_cycles = 0;
  int      quiet_cycles = 0;
  bit      send_idle = 1'b1;
  bit      recv_idle = 1'b1;

  logic    cur_mode = KEEP_MODE_RESET;
  count_t  cur_keep = KEEP_COUNT_RESET;
  digit_t  cur_digit = MASK_DIGIT_RESET;

  row_t    vectors [NUM_ROWS];

  decimal_digit_masker_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic word_t pow10(input int k);
    word_t p;
    p = 64'd1;
    for (int i = 0; i < k; i++) p = p * 64'd10;
    return p;
  endfunction

  function automatic masked_t mask_digits(input word_t v, input logic mode,
                                          input count_t keep, input digit_t dig);
    masked_t r;
    logic    neg;
    word_t   mag;
    word_t   tmp;
    word_t   acc;
    word_t   d;
    int      n;
    int      m;
    neg = v[DATA_W-1];
    mag = neg ? (~v + 64'd1) : v;
    tmp = mag;
    n = 0;
    while (tmp != 0) begin
      tmp = tmp / 64'd10;
      n++;
    end
    r.ovf = 1'b0;
    if (int'(keep) >= n) begin
      r.value = v;
      return r;
    end
    d = (dig > DIGIT_MAX) ? word_t'(DIGIT_MAX) : word_t'(dig);
    if (mode == 1'b0) begin
      m = n - int'(keep);
      acc = (mag / pow10(m)) * pow10(m);
      for (int i = 0; i < m; i++) acc = acc + d * pow10(i);
    end else begin
      acc = mag % pow10(int'(keep));
      for (int i = int'(keep); i < n; i++) acc = acc + d * pow10(i);
    end
    if (!neg) begin
      if (acc > POS_LIMIT) begin
        acc = POS_LIMIT;
        r.ovf = 1'b1;
      end
      r.value = acc;
    end else begin
      if (acc > NEG_LIMIT) begin
        acc = NEG_LIMIT;
        r.ovf = 1'b1;
      end
      r.value = ~acc + 64'd1;
    end
    return r;
  endfunction

  function automatic word_t draw_value();
    word_t v;
    word_t lo;
    word_t span;
    int    kind;
    int    len;
    kind = $urandom_range(0, 9);
    if (kind <= 2) begin
      v = {$urandom, $urandom};
    end else if (kind <= 8) begin
      len = $urandom_range(1, 19);
      lo = pow10(len - 1);
      span = (len == 19) ? (POS_LIMIT - lo + 64'd1) : (pow10(len) - lo);
      v = lo + ({$urandom, $urandom} % span);
      if ($urandom_range(0, 1) == 1) v = ~v + 64'd1;
    end else begin
      case ($urandom_range(0, 6))
        0: v = '0;
        1: v = POS_LIMIT;
        2: v = NEG_LIMIT;
        3: v = NEG_LIMIT + 64'd1;
        4: v = POS_LIMIT - 64'd1;
        5: v = 64'd1;
        default: v = '1;
      endcase
    end
    return v;
  endfunction

  // writes all three registers back to back; unused upper bits are noise
  task automatic program_regs(input logic mode, input count_t keep, input digit_t dig);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_KEEP_MODE;
    cfg_data  <= {4'($urandom), mode};
    @(posedge clk);
    cfg_index <= CFG_KEEP_COUNT;
    cfg_data  <= keep;
    @(posedge clk);
    cfg_index <= CFG_MASK_DIGIT;
    cfg_data  <= {1'($urandom), dig};
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_mode  = mode;
    cur_keep  = keep;
    cur_digit = dig;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (awaited_masks.size() != 0) @(posedge clk);
  endtask

  task automatic offer_value(input word_t v, input logic typed, input masked_t typed_res);
    int gap;
    gap = send_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk); while (!s_axis_tready);
    if (typed) awaited_masks.push_back(typed_res);
    else awaited_masks.push_back(mask_digits(v, cur_mode, cur_keep, cur_digit));
  endtask

  initial begin : stimulus
    row_t   row;
    logic   mode;
    count_t keep;
    digit_t dig;
    vectors = '{
      '{1'b0, 5'd4, 4'd1, 64'd0, 1'b1, 64'd0, 1'b0},
      '{1'b0, 5'd4, 4'd1, 64'd123456789, 1'b1, 64'd123411111, 1'b0},
      '{1'b0, 5'd4, 4'd1, -64'd123456789, 1'b1, -64'd123411111, 1'b0},
      '{1'b0, 5'd4, 4'd1, 64'd1234, 1'b1, 64'd1234, 1'b0},
      '{1'b0, 5'd4, 4'd1, POS_LIMIT, 1'b1, 64'd9223111111111111111, 1'b0},
      '{1'b0, 5'd4, 4'd1, NEG_LIMIT, 1'b1, -64'd9223111111111111111, 1'b0},
      '{1'b0, 5'd0, 4'd9, POS_LIMIT, 1'b1, POS_LIMIT, 1'b1},
      '{1'b0, 5'd0, 4'd9, NEG_LIMIT, 1'b1, NEG_LIMIT, 1'b1},
      '{1'b0, 5'd0, 4'd9, 64'd1, 1'b1, 64'd9, 1'b0},
      '{1'b0, 5'd0, 4'd9, -64'd5, 1'b1, -64'd9, 1'b0},
      '{1'b0, 5'd0, 4'd9, 64'd0, 1'b1, 64'd0, 1'b0},
      '{1'b1, 5'd31, 4'd15, NEG_LIMIT, 1'b1, NEG_LIMIT, 1'b0},
      '{1'b1, 5'd31, 4'd15, POS_LIMIT, 1'b1, POS_LIMIT, 1'b0},
      '{1'b1, 5'd31, 4'd15, -64'd1, 1'b1, -64'd1, 1'b0},
      '{1'b1, 5'd2, 4'd15, 64'd12345, 1'b1, 64'd99945, 1'b0},
      '{1'b1, 5'd2, 4'd15, POS_LIMIT, 1'b1, POS_LIMIT, 1'b1},
      '{1'b1, 5'd2, 4'd15, NEG_LIMIT + 64'd1, 1'b1, NEG_LIMIT, 1'b1},
      '{1'b1, 5'd2, 4'd15, 64'd100, 1'b0, 64'd0, 1'b0},
      '{1'b1, 5'd0, 4'd0, 64'd987654321, 1'b1, 64'd0, 1'b0},
      '{1'b1, 5'd0, 4'd0, -64'd987654321, 1'b1, 64'd0, 1'b0},
      '{1'b0, 5'd18, 4'd10, NEG_LIMIT, 1'b1, NEG_LIMIT, 1'b1},
      '{1'b0, 5'd18, 4'd10, POS_LIMIT, 1'b1, POS_LIMIT, 1'b1},
      '{1'b0, 5'd18, 4'd10, 64'h5555_5555_5555_5555, 1'b0, 64'd0, 1'b0},
      '{1'b0, 5'd19, 4'd3, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0, 1'b0},
      '{1'b0, 5'd19, 4'd3, NEG_LIMIT, 1'b1, NEG_LIMIT, 1'b0}
    };
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table; first rows run on reset settings
    for (int r = 0; r < NUM_ROWS; r++) begin
      row = vectors[r];
      if (row.mode != cur_mode || row.keep != cur_keep || row.dig != cur_digit) begin
        drain_results();
        program_regs(row.mode, row.keep, row.dig);
      end
      offer_value(row.value, row.typed, '{row.want, row.want_ovf});
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin mode = 1'b0; keep = 5'd0;  dig = 4'd0;  end
        1: begin mode = 1'b1; keep = 5'd0;  dig = 4'd9;  end
        2: begin mode = 1'b0; keep = 5'd31; dig = 4'd15; end
        3: begin mode = 1'b1; keep = 5'd19; dig = 4'd9;  end
        4: begin mode = 1'b0; keep = 5'd1;  dig = 4'd5;  end
        5: begin mode = 1'b1; keep = 5'd18; dig = 4'd12; end
        default: begin
          mode = 1'($urandom);
          keep = ($urandom_range(0, 3) == 0) ? count_t'($urandom_range(20, 31))
                                             : count_t'($urandom_range(0, 19));
          dig  = digit_t'($urandom_range(0, 15));
        end
      endcase
      drain_results();
      program_regs(mode, keep, dig);
      send_idle = (ph % 3) != 1;
      recv_idle = (ph % 4) != 2;
      // long receiver hold while items keep coming
      if (ph == 2 || ph == 7) begin
        send_idle   = 1'b0;
        hold_cycles = 200;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) offer_value(draw_value(), 1'b0, '0);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (awaited_masks.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, awaited_masks.size());
      errors++;
    end
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : result_checker
    masked_t want;
    int      stall;
    while (rst) @(posedge clk);
    forever begin
      stall = recv_idle ? $urandom_range(0, 10) : 0;
      stall = stall + hold_cycles;
      hold_cycles = 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      if (awaited_masks.size() == 0) begin
        $display("%0t: unexpected item, value %0d overflow %0b", $time,
                 $signed(m_axis_tdata), m_axis_tuser);
        errors++;
      end else begin
        want = awaited_masks.pop_front();
        if (m_axis_tdata !== want.value) begin
          $display("%0t: masked_value expected %0d actual %0d", $time,
                   $signed(want.value), $signed(m_axis_tdata));
          errors++;
        end
        if (m_axis_tuser !== want.ovf) begin
          $display("%0t: overflow expected %0b actual %0b", $time, want.ovf,
                   m_axis_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
